[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing when SYNTH is
// defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

[hdl/bpad_pkg.sv]
// ---------------------------------------------------------------------------
// Byte phase alignment detector package
// Types and fixed constants shared by the detector modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpad_pkg;

    // Width of the sample count register and its reset value.
    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MIN = 13'd3;

    // Reported sums saturate at the top of this width.
    localparam int SUM_W = 28;
    localparam logic [SUM_W-1:0] SUM_MAX = 28'hFFF_FFFF;

    // Magnitude of the difference of two signed 16-bit words.
    localparam int DIFF_W = 16;

    typedef enum logic [1:0] {
        PHASE_ALIGNED   = 2'd0,
        PHASE_SHIFTED   = 2'd1,
        PHASE_UNDECIDED = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [SUM_W-1:0] even_sum;
        logic [SUM_W-1:0] odd_sum;
    } result_t;

    // What the window tracker reports for the byte in the input register.
    typedef struct packed {
        logic    window_end;
        result_t result;
    } win_status_t;

endpackage

[hdl/bpad_window.sv]
// ---------------------------------------------------------------------------
// Byte phase window tracker
// Holds the per-window state and, for the byte presented, works out the
// state update and the window result in one pass of logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpad_window #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [7:0]                    data_byte,
    input  logic [bpad_pkg::COUNT_W-1:0]  sample_count,
    output bpad_pkg::win_status_t         status
);

    localparam int IDX_W = $clog2(2 * MAX_SAMPLES);
    localparam int N_W   = $clog2(MAX_SAMPLES + 1);

    logic [IDX_W-1:0]            index_reg, index_next;
    logic [7:0]                  prev_byte_reg, prev_byte_next;
    logic [15:0]                 even_word_reg, even_word_next;
    logic [15:0]                 odd_word_reg, odd_word_next;
    logic [bpad_pkg::SUM_W-1:0]  even_acc_reg, even_acc_next;
    logic [bpad_pkg::SUM_W-1:0]  odd_acc_reg, odd_acc_next;

    logic [31:0]                 count_ext;
    logic [31:0]                 n_full;
    logic [IDX_W-1:0]            n_idx;
    logic [IDX_W-1:0]            end_idx;
    logic [IDX_W-1:0]            half_idx;
    logic [15:0]                 word;
    logic [15:0]                 ref_word;
    logic signed [16:0]          diff;
    logic [bpad_pkg::DIFF_W-1:0] diff_mag;
    logic [bpad_pkg::SUM_W:0]    sum_wide;
    logic [bpad_pkg::SUM_W-1:0]  sum_sat;
    logic                        even_take, odd_take;
    logic                        even_add, odd_add;
    logic                        window_end;

    // Clamp the requested count into the supported window range.
    always_comb begin
        count_ext = 32'(sample_count);
        if (sample_count < bpad_pkg::COUNT_MIN) begin
            n_full = 32'(bpad_pkg::COUNT_MIN);
        end else if (count_ext > 32'(MAX_SAMPLES)) begin
            n_full = 32'(MAX_SAMPLES);
        end else begin
            n_full = count_ext;
        end
        n_idx   = IDX_W'(n_full[N_W-1:0]);
        end_idx = IDX_W'({1'b0, n_idx, 1'b0} - (IDX_W + 2)'(1));
    end

    assign half_idx = {1'b0, index_reg[IDX_W-1:1]};
    assign word     = {prev_byte_reg, data_byte};

    // Odd byte index closes an even-offset word; even index closes an odd one.
    assign even_take = index_reg[0] && (half_idx <= n_idx - IDX_W'(2));
    assign even_add  = even_take && (half_idx >= IDX_W'(1));
    assign odd_take  = !index_reg[0] && (half_idx >= IDX_W'(1))
                       && (half_idx <= n_idx - IDX_W'(1));
    assign odd_add   = odd_take && (half_idx >= IDX_W'(2));

    // Only one phase updates per byte, so one subtractor and adder serve both.
    assign ref_word = index_reg[0] ? even_word_reg : odd_word_reg;
    assign diff     = $signed({word[15], word}) - $signed({ref_word[15], ref_word});
    assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
    assign sum_wide = {1'b0, (index_reg[0] ? even_acc_reg : odd_acc_reg)}
                      + (bpad_pkg::SUM_W + 1)'(diff_mag);
    assign sum_sat  = sum_wide[bpad_pkg::SUM_W] ? bpad_pkg::SUM_MAX
                                                : sum_wide[bpad_pkg::SUM_W-1:0];

    assign window_end = (index_reg >= end_idx);

    always_comb begin
        even_acc_next  = even_add ? sum_sat : even_acc_reg;
        odd_acc_next   = odd_add ? sum_sat : odd_acc_reg;
        even_word_next = even_take ? word : even_word_reg;
        odd_word_next  = odd_take ? word : odd_word_reg;
        prev_byte_next = data_byte;
        index_next     = index_reg + IDX_W'(1);

        status.window_end      = window_end;
        status.result.even_sum = even_acc_next;
        status.result.odd_sum  = odd_acc_next;
        if (even_acc_next < odd_acc_next) begin
            status.result.phase = bpad_pkg::PHASE_ALIGNED;
        end else if (odd_acc_next < even_acc_next) begin
            status.result.phase = bpad_pkg::PHASE_SHIFTED;
        end else begin
            status.result.phase = bpad_pkg::PHASE_UNDECIDED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg     <= '0;
            prev_byte_reg <= '0;
            even_word_reg <= '0;
            odd_word_reg  <= '0;
            even_acc_reg  <= '0;
            odd_acc_reg   <= '0;
        end else if (step_en) begin
            if (window_end) begin
                index_reg     <= '0;
                prev_byte_reg <= '0;
                even_word_reg <= '0;
                odd_word_reg  <= '0;
                even_acc_reg  <= '0;
                odd_acc_reg   <= '0;
            end else begin
                index_reg     <= index_next;
                prev_byte_reg <= prev_byte_next;
                even_word_reg <= even_word_next;
                odd_word_reg  <= odd_word_next;
                even_acc_reg  <= even_acc_next;
                odd_acc_reg   <= odd_acc_next;
            end
        end
    end

endmodule

[hdl/byte_phase_alignment_detector.sv]
// Byte phase alignment detector.
//
// Bytes of a big-endian signed 16-bit sample stream enter on the s_ channel,
// one byte per transfer. The block forms 16-bit words at both byte phases and
// sums the absolute differences of consecutive words in each phase over a
// window of sample_count words (2 * sample_count bytes). On the last byte of a
// window one word leaves on the m_ channel carrying the smoother phase and both
// sums, and the next window starts with the following byte.
//
// Throughput is one byte per cycle while s_tready is high: the work on a byte
// is a single subtract, saturating add and compare between the input register
// and the result register, from which m_tvalid is driven.
// While the receiver stalls, the result word holds and the input register
// keeps taking bytes until a second window end has to wait behind it, then
// s_tready drops.
//
// The user must write the sample count via cfg_wr_en / cfg_wr_data only while
// the block is idle; the block does not enforce this. Reset sets it to 1024,
// clears the window and empties both registers; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Byte phase alignment detector, top level
// Input register, window tracker and result register with stream handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module byte_phase_alignment_detector #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration: sample_count.
    input  logic                         cfg_wr_en,
    input  logic [bpad_pkg::COUNT_W-1:0] cfg_wr_data,
    // Input channel.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // [7:0] data_byte
    // Result channel.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [63:0]                  m_tdata   // [1:0] phase, [29:2] even_sum,
                                                   // [57:30] odd_sum, [63:58] zero
);

    logic [bpad_pkg::COUNT_W-1:0] sample_count_reg;

    // Input register holding one byte.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Result register.
    logic        out_valid_reg;
    logic [63:0] out_data_reg;

    bpad_pkg::win_status_t status;
    logic                  out_free;
    logic                  advance;

    // The byte in the input register moves on unless it ends a window and the
    // previous result is still waiting.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!status.window_end || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= bpad_pkg::COUNT_RESET;
        end else if (cfg_wr_en) begin
            sample_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    bpad_window #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .data_byte    (in_byte_reg),
        .sample_count (sample_count_reg),
        .status       (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && status.window_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && status.window_end) begin
            out_data_reg <= {6'b0, status.result.odd_sum, status.result.even_sum,
                             status.result.phase};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A stall upstream only happens with a byte held in the input register.
    `ASSERT_PROP(a_stall_has_byte, aclk, aresetn, !s_tready |-> in_valid_reg, "s_tready low with empty input register")
    // A window end that advances always produces a result word next cycle.
    `ASSERT_PROP(a_end_gives_result, aclk, aresetn, (advance && status.window_end) |=> m_tvalid, "window end did not produce a result")
    // The reported phase agrees with the sums it carries.
    `ASSERT_PROP(a_phase_aligned, aclk, aresetn, (m_tvalid && m_tdata[1:0] == bpad_pkg::PHASE_ALIGNED) |-> (m_tdata[29:2] < m_tdata[57:30]), "aligned phase with even sum not smaller")
    `ASSERT_PROP(a_phase_undecided, aclk, aresetn, (m_tvalid && m_tdata[1:0] == bpad_pkg::PHASE_UNDECIDED) |-> (m_tdata[29:2] == m_tdata[57:30]), "undecided phase with unequal sums")
    // A waiting result must not be overwritten by a new window end.
    `ASSERT_NEVER(a_no_overwrite, aclk, aresetn, advance && status.window_end && out_valid_reg && !m_tready, "result overwritten while stalled")

endmodule
